// ----- hdl/scma_pkg.sv -----
// ----------------------------------------------------------------------------
// Sector cache miss allocator package
// Shared sizes, codes and the control bundle of the stamp scan unit.
// ----------------------------------------------------------------------------
package scma_pkg;

  localparam int NUM_BLOCKS  = 128;
  localparam int BLK_W       = 7;
  localparam int SECTOR_W    = 16;
  localparam int STAMP_W     = 32;
  localparam int CT_DEPTH    = 65536;
  localparam int MAP_DEPTH   = 65536;
  localparam int LINK_W      = 8;
  localparam logic [LINK_W-1:0] LINK_NIL = 8'hFF;

  // Function codes carried on the input tuser.
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_MISS   = 2'd1;
  localparam logic [1:0] FUNC_LOOKUP = 2'd2;

  // Replacement modes.
  localparam logic [1:0] MODE_LRU  = 2'd0;
  localparam logic [1:0] MODE_MRU  = 2'd1;
  localparam logic [1:0] MODE_RR   = 2'd2;
  localparam logic [1:0] MODE_LIST = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_REPLACE_MODE = 2'd0;
  localparam logic [1:0] CFG_CLUSTER_LOG2 = 2'd1;

  // Control bundle from the sequencer to the stamp scan unit.
  typedef struct packed {
    logic               start;
    logic               want_max;
    logic               wr_en;
    logic [BLK_W-1:0]   wr_blk;
    logic [STAMP_W-1:0] wr_stamp;
  } scan_ctl_t;

endpackage

// ----- hdl/scma_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module scma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/scma_stamp_scan.sv -----
// ----------------------------------------------------------------------------
// Stamp scan unit
// Holds the block stamps and walks all blocks with one comparator to find the
// first free block, or else the smallest or largest stamp.
// ----------------------------------------------------------------------------
module scma_stamp_scan (
  input  logic                                clk,
  input  logic                                rst,
  input  scma_pkg::scan_ctl_t                 ctl,
  input  logic [scma_pkg::NUM_BLOCKS-1:0]     blk_valid,
  output logic                                done,
  output logic [scma_pkg::BLK_W-1:0]          victim
);

  logic [scma_pkg::BLK_W:0]          cnt;
  logic                              busy;
  logic                              found_free;
  logic                              want_max;
  logic [scma_pkg::STAMP_W-1:0]      best_stamp;
  logic [scma_pkg::NUM_BLOCKS-1:0]   stamp_set;
  logic [scma_pkg::STAMP_W-1:0]      rd_data;
  logic [scma_pkg::BLK_W-1:0]        ent;
  logic [scma_pkg::STAMP_W-1:0]      ent_stamp;
  logic                              better;

  scma_ram #(.WIDTH(scma_pkg::STAMP_W), .DEPTH(scma_pkg::NUM_BLOCKS)) u_stamp_ram (
    .clk     (clk),
    .wr_en   (ctl.wr_en),
    .wr_addr (ctl.wr_blk),
    .wr_data (ctl.wr_stamp),
    .rd_en   (busy),
    .rd_addr (cnt[scma_pkg::BLK_W-1:0]),
    .rd_data (rd_data)
  );

  // The entry whose stamp arrives this cycle; a never written stamp is zero.
  assign ent       = cnt[scma_pkg::BLK_W-1:0] - 1'b1;
  assign ent_stamp = stamp_set[ent] ? rd_data : '0;
  assign better    = (ent == '0) ||
                     (want_max ? (ent_stamp > best_stamp) : (ent_stamp < best_stamp));

  // Scan sequencer and shared comparator.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      done      <= 1'b0;
      cnt       <= '0;
      stamp_set <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.wr_en) begin
        stamp_set[ctl.wr_blk] <= 1'b1;
      end
      if (ctl.start) begin
        busy       <= 1'b1;
        cnt        <= '0;
        found_free <= 1'b0;
        want_max   <= ctl.want_max;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt != '0 && !found_free) begin
          if (!blk_valid[ent]) begin
            found_free <= 1'b1;
            victim     <= ent;
          end else if (better) begin
            victim     <= ent;
            best_stamp <= ent_stamp;
          end
        end
        if (cnt == (scma_pkg::BLK_W+1)'(scma_pkg::NUM_BLOCKS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hdl/sector_cache_miss_allocator.sv -----
// ----------------------------------------------------------------------------
// Sector cache miss allocator
// Picks cache blocks for ROM sector misses and keeps the sector map.
// ----------------------------------------------------------------------------
// Input beats arrive on s_tvalid/s_tready with the function code on s_tuser:
// load a cluster table entry, handle a miss, or look up the sector map. Every
// input beat gives exactly one result beat on m_tvalid/m_tready.
// Configuration writes (replacement mode, cluster size) use cfg_valid,
// cfg_index and cfg_data; cfg_ready is always high. Write only while idle.
// One item is worked on at a time; s_tready is high only when idle.
// A lookup reads the sector map, then the owner of the mapped block. In the
// stamp modes a miss has one comparator walk the 128 stamps one at a time
// out of the stamp memory.
// The result sits in an output register; the block returns to idle and takes
// the next beat while it waits, and holds a further result until the receiver
// takes the first. Reset empties the cache and the sector map at once (map
// entries are checked against each block's owner, so no clearing pass is
// needed) and sets the list order 0 to 127; the cluster table is not cleared.
// ----------------------------------------------------------------------------
module sector_cache_miss_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // rom_address[24:0], table_slot[40:25],
                                 // table_first_sector[72:41], zero fill
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // block_number[6:0], storage_sector[38:7],
                                 // byte_offset[47:39], is_cached[48],
                                 // evicted[49], evicted_sector_index[65:50],
                                 // zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_MAP       = 10'b0000000010,
    S_PRIOR_RD  = 10'b0000000100,
    S_PRIOR_CHK = 10'b0000001000,
    S_LIST_RD   = 10'b0000010000,
    S_LIST_WR   = 10'b0000100000,
    S_SCAN      = 10'b0001000000,
    S_EVICT_RD  = 10'b0010000000,
    S_EVICT     = 10'b0100000000,
    S_DONE      = 10'b1000000000
  } state_t;

  state_t state;

  logic [1:0]                      replace_mode;
  logic [3:0]                      cluster_log2;
  logic [1:0]                      func_r;
  logic [scma_pkg::SECTOR_W-1:0]   sector_r;
  logic [8:0]                      offset_r;
  logic [scma_pkg::LINK_W-1:0]     raw_r;
  logic                            prior_hit;
  logic [scma_pkg::BLK_W-1:0]      blk_r;
  logic [scma_pkg::NUM_BLOCKS-1:0] blk_valid;
  logic [scma_pkg::NUM_BLOCKS-1:0] link_set;
  logic [scma_pkg::STAMP_W-1:0]    miss_counter;
  logic [scma_pkg::BLK_W-1:0]      list_head;
  logic [scma_pkg::BLK_W-1:0]      list_tail;

  logic [scma_pkg::BLK_W-1:0]      res_block;
  logic [31:0]                     res_storage;
  logic                            res_cached;
  logic                            res_evicted;
  logic [scma_pkg::SECTOR_W-1:0]   res_ev_idx;

  logic [2:0]                      k;
  logic [scma_pkg::SECTOR_W-1:0]   cidx;
  logic [scma_pkg::SECTOR_W-1:0]   low;
  logic                            hit;
  logic [scma_pkg::LINK_W-1:0]     next_link;
  logic [scma_pkg::BLK_W-1:0]      rr_blk;
  logic [scma_pkg::STAMP_W-1:0]    rr_next;
  logic                            out_load;

  logic [31:0]                     ct_rd_data;
  logic [scma_pkg::LINK_W-1:0]     map_rd_data;
  logic [scma_pkg::SECTOR_W-1:0]   owner_rd_data;
  logic [scma_pkg::LINK_W-1:0]     link_rd_data;
  logic                            owner_rd_en;
  logic [scma_pkg::BLK_W-1:0]      owner_rd_addr;
  logic                            link_wr_en;
  logic [scma_pkg::BLK_W-1:0]      link_wr_addr;
  logic [scma_pkg::LINK_W-1:0]     link_wr_data;

  scma_pkg::scan_ctl_t             scan_ctl;
  logic                            scan_done;
  logic [scma_pkg::BLK_W-1:0]      scan_victim;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // A finished result moves into the output register when it is empty or being taken.
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  // Cluster index and the sector's place inside its cluster.
  assign k    = (cluster_log2 < 4'd9) ? 3'd0 : 3'(cluster_log2 - 4'd9);
  assign cidx = sector_r >> k;
  assign low  = sector_r & ((scma_pkg::SECTOR_W'(1) << k) - 1'b1);

  // A map entry counts only if its block is valid and still owns the sector;
  // an entry that was never written reads as not cached.
  always_comb begin
    hit = 1'b0;
    if (!raw_r[scma_pkg::LINK_W-1]) begin
      if (blk_valid[raw_r[scma_pkg::BLK_W-1:0]] && (owner_rd_data == sector_r)) begin
        hit = 1'b1;
      end
    end
  end

  // List successor of the head; entries never written keep their reset link.
  always_comb begin
    if (link_set[list_head]) begin
      next_link = link_rd_data;
    end else if (list_head == scma_pkg::BLK_W'(scma_pkg::NUM_BLOCKS - 1)) begin
      next_link = scma_pkg::LINK_NIL;
    end else begin
      next_link = scma_pkg::LINK_W'(list_head) + 1'b1;
    end
  end

  // Round-robin pointer step.
  always_comb begin
    if (miss_counter >= scma_pkg::STAMP_W'(scma_pkg::NUM_BLOCKS)) begin
      rr_blk  = '0;
      rr_next = scma_pkg::STAMP_W'(1);
    end else begin
      rr_blk  = miss_counter[scma_pkg::BLK_W-1:0];
      rr_next = (rr_blk == scma_pkg::BLK_W'(scma_pkg::NUM_BLOCKS - 1)) ? '0 :
                miss_counter + 1'b1;
    end
  end

  // Owner memory read address and list memory writes.
  always_comb begin
    owner_rd_en   = 1'b0;
    owner_rd_addr = blk_r;
    link_wr_en    = 1'b0;
    link_wr_addr  = list_tail;
    link_wr_data  = scma_pkg::LINK_W'(list_head);
    case (state)
      S_PRIOR_RD: begin
        owner_rd_en   = 1'b1;
        owner_rd_addr = map_rd_data[scma_pkg::BLK_W-1:0];
      end
      S_EVICT_RD: begin
        owner_rd_en = 1'b1;
      end
      S_LIST_RD: begin
        link_wr_en = 1'b1;
      end
      S_LIST_WR: begin
        link_wr_en   = 1'b1;
        link_wr_addr = blk_r;
        link_wr_data = scma_pkg::LINK_NIL;
      end
      default: begin
      end
    endcase
  end

  // Stamp unit control.
  always_comb begin
    scan_ctl.start    = (state == S_PRIOR_CHK) && (func_r == scma_pkg::FUNC_MISS) &&
                        !replace_mode[1];
    scan_ctl.want_max = (replace_mode == scma_pkg::MODE_MRU);
    scan_ctl.wr_en    = (state == S_EVICT) && !replace_mode[1];
    scan_ctl.wr_blk   = blk_r;
    scan_ctl.wr_stamp = miss_counter;
  end

  scma_ram #(.WIDTH(32), .DEPTH(scma_pkg::CT_DEPTH)) u_cluster_ram (
    .clk     (clk),
    .wr_en   (s_tvalid && s_tready && (s_tuser == scma_pkg::FUNC_LOAD)),
    .wr_addr (s_tdata[40:25]),
    .wr_data (s_tdata[72:41]),
    .rd_en   (state == S_MAP),
    .rd_addr (cidx),
    .rd_data (ct_rd_data)
  );

  scma_ram #(.WIDTH(scma_pkg::LINK_W), .DEPTH(scma_pkg::MAP_DEPTH)) u_map_ram (
    .clk     (clk),
    .wr_en   (state == S_EVICT),
    .wr_addr (sector_r),
    .wr_data (scma_pkg::LINK_W'(blk_r)),
    .rd_en   (state == S_MAP),
    .rd_addr (sector_r),
    .rd_data (map_rd_data)
  );

  scma_ram #(.WIDTH(scma_pkg::SECTOR_W), .DEPTH(scma_pkg::NUM_BLOCKS)) u_owner_ram (
    .clk     (clk),
    .wr_en   (state == S_EVICT),
    .wr_addr (blk_r),
    .wr_data (sector_r),
    .rd_en   (owner_rd_en),
    .rd_addr (owner_rd_addr),
    .rd_data (owner_rd_data)
  );

  scma_ram #(.WIDTH(scma_pkg::LINK_W), .DEPTH(scma_pkg::NUM_BLOCKS)) u_link_ram (
    .clk     (clk),
    .wr_en   (link_wr_en),
    .wr_addr (link_wr_addr),
    .wr_data (link_wr_data),
    .rd_en   (state == S_PRIOR_CHK),
    .rd_addr (list_head),
    .rd_data (link_rd_data)
  );

  scma_stamp_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctl       (scan_ctl),
    .blk_valid (blk_valid),
    .done      (scan_done),
    .victim    (scan_victim)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      replace_mode <= scma_pkg::MODE_LIST;
      cluster_log2 <= 4'd9;
    end else if (cfg_valid) begin
      case (cfg_index)
        scma_pkg::CFG_REPLACE_MODE: replace_mode <= cfg_data[1:0];
        scma_pkg::CFG_CLUSTER_LOG2: cluster_log2 <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      blk_valid    <= '0;
      link_set     <= '0;
      miss_counter <= '0;
      list_head    <= '0;
      list_tail    <= scma_pkg::BLK_W'(scma_pkg::NUM_BLOCKS - 1);
      m_tvalid     <= 1'b0;
    end else begin
      // Output register: load a finished result, or clear a taken beat.
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (link_wr_en) begin
        link_set[link_wr_addr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            func_r      <= s_tuser;
            sector_r    <= s_tdata[24:9];
            res_block   <= '0;
            res_storage <= '0;
            res_cached  <= 1'b0;
            res_evicted <= 1'b0;
            res_ev_idx  <= '0;
            if (s_tuser == scma_pkg::FUNC_MISS || s_tuser == scma_pkg::FUNC_LOOKUP) begin
              offset_r <= s_tdata[8:0];
              state    <= S_MAP;
            end else begin
              // Loads and the unused code answer with every field zero.
              offset_r <= '0;
              state    <= S_DONE;
            end
          end
        end
        S_MAP: begin
          state <= S_PRIOR_RD;
        end
        S_PRIOR_RD: begin
          raw_r <= map_rd_data;
          state <= S_PRIOR_CHK;
        end
        S_PRIOR_CHK: begin
          prior_hit <= hit;
          if (func_r == scma_pkg::FUNC_LOOKUP) begin
            res_cached <= hit;
            res_block  <= hit ? raw_r[scma_pkg::BLK_W-1:0] : '0;
            state      <= S_DONE;
          end else begin
            case (replace_mode)
              scma_pkg::MODE_RR: begin
                blk_r        <= rr_blk;
                miss_counter <= rr_next;
                state        <= S_EVICT_RD;
              end
              scma_pkg::MODE_LIST: begin
                blk_r <= list_head;
                if (list_head == list_tail) begin
                  state <= S_EVICT_RD;
                end else begin
                  state <= S_LIST_RD;
                end
              end
              default: begin
                state <= S_SCAN;
              end
            endcase
          end
        end
        S_LIST_RD: begin
          // Move the head block to the tail.
          if (!next_link[scma_pkg::LINK_W-1]) begin
            list_head <= next_link[scma_pkg::BLK_W-1:0];
          end
          state <= S_LIST_WR;
        end
        S_LIST_WR: begin
          list_tail <= blk_r;
          state     <= S_EVICT_RD;
        end
        S_SCAN: begin
          if (scan_done) begin
            blk_r <= scan_victim;
            state <= S_EVICT_RD;
          end
        end
        S_EVICT_RD: begin
          state <= S_EVICT;
        end
        S_EVICT: begin
          if (blk_valid[blk_r]) begin
            res_evicted <= 1'b1;
            res_ev_idx  <= owner_rd_data;
          end
          if (prior_hit && raw_r[scma_pkg::BLK_W-1:0] != blk_r) begin
            blk_valid[raw_r[scma_pkg::BLK_W-1:0]] <= 1'b0;
          end
          blk_valid[blk_r] <= 1'b1;
          if (!replace_mode[1]) begin
            miss_counter <= miss_counter + 1'b1;
          end
          res_block   <= blk_r;
          res_storage <= ct_rd_data + 32'(low);
          res_cached  <= 1'b1;
          state       <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            m_tdata <= {6'd0, res_ev_idx, res_evicted, res_cached, offset_r,
                        res_storage, res_block};
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
